FILE: design/rfsla_pkg.sv
// ----------------------------------------------------------------------------
// rfsla_pkg
// Shared types, codes and constants of the sensor learn and alarm table.
// ----------------------------------------------------------------------------
package rfsla_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

    localparam logic [2:0] REQ_ID     = 3'd0;
    localparam logic [2:0] REQ_POLL   = 3'd1;
    localparam logic [2:0] REQ_LEARN  = 3'd2;
    localparam logic [2:0] REQ_ENABLE = 3'd3;
    localparam logic [2:0] REQ_DELETE = 3'd4;

    localparam logic [3:0] EV_NONE    = 4'd0;
    localparam logic [3:0] EV_LEARNED = 4'd1;
    localparam logic [3:0] EV_DUP     = 4'd2;
    localparam logic [3:0] EV_FULL    = 4'd3;
    localparam logic [3:0] EV_TIMEOUT = 4'd4;
    localparam logic [3:0] EV_ALARM   = 4'd5;
    localparam logic [3:0] EV_ARMED   = 4'd6;
    localparam logic [3:0] EV_DISARM  = 4'd7;
    localparam logic [3:0] EV_REJECT  = 4'd8;

    localparam logic [2:0] T_DOOR    = 3'd1;
    localparam logic [2:0] T_WRIST   = 3'd2;
    localparam logic [2:0] T_REMOTE  = 3'd3;
    localparam logic [2:0] T_SMOKE   = 3'd4;
    localparam logic [2:0] T_CURTAIN = 3'd5;
    localparam logic [2:0] T_PIR     = 3'd6;
    localparam logic [2:0] T_GAS     = 3'd7;

    localparam logic [1:0] CFG_WINDOW  = 2'd0;
    localparam logic [1:0] CFG_GAP     = 2'd1;
    localparam logic [1:0] CFG_COUNT   = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT = 2'd3;

    localparam logic [7:0] ARM_BITS    = 8'h0C;
    localparam logic [7:0] PANIC_BITS  = 8'h30;
    localparam logic [7:0] DISARM_BITS = 8'h03;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;      // capture the item
        logic              clr_scan;  // restart the slot pointer
        logic              scan_step; // look at the current slot
        logic              adv;       // advance slot pointer
        logic [2:0]        scan_kind; // which scan is running
        logic              finish;    // apply the decision and emit
    } rfsla_cmd_t;

    localparam logic [2:0] SCAN_DUP   = 3'd0;
    localparam logic [2:0] SCAN_MATCH = 3'd1;
    localparam logic [2:0] SCAN_MULTI = 3'd2;
    localparam logic [2:0] SCAN_CROSS = 3'd3;
    localparam logic [2:0] SCAN_FREE  = 3'd4;

    typedef struct packed {
        logic last; // pointer on the last slot
        logic hit;  // current slot ends the scan
    } rfsla_sts_t;

endpackage

FILE: design/rf_sensor_learn_and_alarm_table_core.sv
// ----------------------------------------------------------------------------
// rf_sensor_learn_and_alarm_table_core
// Learned wireless sensor table with learn mode and alarm rules.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its fields are
// captured at that edge and need not be held. Each item gives exactly one
// result, shown for one cycle with done high; the receiver cannot stall it.
// Polls, enable and delete requests need no table walk. A learn request or a
// received ID in learn mode walks the table once, and a received ID that meets
// the multi-sensor rules up to three times: the table is walked one slot a cycle,
// once to find the slot, once to count door and PIR sensors, once for the
// cross-sensor check. Busy stays high until the result is shown.
// Configuration is written with cfg_we, cfg_index and cfg_data while idle.
// Reset clears the table, loads the register defaults and arms the system.
// ----------------------------------------------------------------------------
module rf_sensor_learn_and_alarm_table_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [31:0] sensor_id,
    input  logic [31:0] now_seconds,
    input  logic [2:0]  new_type,
    input  logic [7:0]  entry_index,
    input  logic        entry_enable,
    output logic        done,
    output logic [3:0]  event_res,
    output logic [3:0]  slot,
    output logic [2:0]  alarm_type
);
    import rfsla_pkg::*;

    rfsla_cmd_t cmd;
    rfsla_sts_t sts;
    logic       learning, judge_multi_needed, cross_needed;

    rfsla_ctrl u_ctrl
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .req_type           (req_type),
        .learning           (learning),
        .sts                (sts),
        .judge_multi_needed (judge_multi_needed),
        .cross_needed       (cross_needed),
        .cmd                (cmd),
        .busy               (busy)
    );

    rfsla_datapath u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .req_type           (req_type),
        .sensor_id          (sensor_id),
        .now_seconds        (now_seconds),
        .new_type           (new_type),
        .entry_index        (entry_index),
        .entry_enable       (entry_enable),
        .cmd                (cmd),
        .sts                (sts),
        .learning           (learning),
        .judge_multi_needed (judge_multi_needed),
        .cross_needed       (cross_needed),
        .done               (done),
        .event_res          (event_res),
        .slot               (slot),
        .alarm_type         (alarm_type)
    );

endmodule

FILE: design/rfsla_ctrl.sv
// ----------------------------------------------------------------------------
// rfsla_ctrl
// Sequencer: decides which table scans an item needs and steps through them.
// ----------------------------------------------------------------------------
module rfsla_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [2:0]           req_type,
    input  logic                 learning,
    input  rfsla_pkg::rfsla_sts_t sts,
    input  logic                 judge_multi_needed,
    input  logic                 cross_needed,
    output rfsla_pkg::rfsla_cmd_t cmd,
    output logic                 busy
);
    import rfsla_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DUP   = 3'd1;
    localparam logic [2:0] S_MATCH = 3'd2;
    localparam logic [2:0] S_MULTI = 3'd3;
    localparam logic [2:0] S_CROSS = 3'd4;
    localparam logic [2:0] S_FREE  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load     = 1'b1;
                    cmd.clr_scan = 1'b1;
                    if (req_type == REQ_ID)
                    begin
                        state_next = learning ? S_DUP : S_MATCH;
                    end
                    else if (req_type == REQ_LEARN)
                    begin
                        state_next = S_FREE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DUP, S_MATCH, S_FREE:
            begin
                cmd.scan_step = 1'b1;
                cmd.scan_kind = (state_reg == S_DUP) ? SCAN_DUP :
                                (state_reg == S_MATCH) ? SCAN_MATCH : SCAN_FREE;
                if (sts.hit || sts.last)
                begin
                    cmd.clr_scan = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.adv = 1'b1;
                end
                if (state_reg == S_MATCH && (sts.hit || sts.last) && judge_multi_needed)
                begin
                    state_next = S_MULTI;
                end
            end
            S_MULTI:
            begin
                cmd.scan_step = 1'b1;
                cmd.scan_kind = SCAN_MULTI;
                if (sts.last)
                begin
                    cmd.clr_scan = 1'b1;
                    state_next   = S_CROSS;
                end
                else
                begin
                    cmd.adv = 1'b1;
                end
            end
            S_CROSS:
            begin
                if (cross_needed)
                begin
                    cmd.scan_step = 1'b1;
                    cmd.scan_kind = SCAN_CROSS;
                    if (sts.last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.adv = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

`ifndef NO_ASSERTIONS
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> busy) else $error("finish outside an item");
    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted item not taken up");
    a_done_returns: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !busy) else $error("no return to idle after finish");
`endif

endmodule

FILE: design/rfsla_datapath.sv
// ----------------------------------------------------------------------------
// rfsla_datapath
// Slot table, configuration registers, learn and arming state and the scan
// logic that walks the table one slot a cycle.
// ----------------------------------------------------------------------------
module rfsla_datapath
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic [2:0]            req_type,
    input  logic [31:0]           sensor_id,
    input  logic [31:0]           now_seconds,
    input  logic [2:0]            new_type,
    input  logic [7:0]            entry_index,
    input  logic                  entry_enable,
    input  rfsla_pkg::rfsla_cmd_t cmd,
    output rfsla_pkg::rfsla_sts_t sts,
    output logic                  learning,
    output logic                  judge_multi_needed,
    output logic                  cross_needed,
    output logic                  done,
    output logic [3:0]            event_res,
    output logic [3:0]            slot,
    output logic [2:0]            alarm_type
);
    import rfsla_pkg::*;

    logic [7:0] window_reg, gap_reg, count_reg, timeout_reg;

    logic [TABLE_SLOTS-1:0] valid_reg, enabled_reg;
    logic [2:0]  type_reg  [TABLE_SLOTS];
    logic [31:0] id_reg    [TABLE_SLOTS];
    logic [31:0] time_reg  [TABLE_SLOTS];
    logic [7:0]  trig_reg  [TABLE_SLOTS];

    logic              learning_reg;
    logic [SLOT_W-1:0] learn_slot_reg;
    logic [7:0]        countdown_reg;
    logic              armed_reg;

    logic [2:0]        req_reg;
    logic [31:0]       sid_reg, now_reg;
    logic [2:0]        nty_reg;
    logic [7:0]        idx_reg;
    logic              en_reg;

    logic [SLOT_W-1:0] ptr_reg;
    logic              found_reg;
    logic [SLOT_W-1:0] hit_slot_reg;
    logic [CNT_W-1:0]  doors_reg, pirs_reg;
    logic              fire_reg;

    logic              cur_match, cur_dup, cur_free;
    logic              multi;
    logic [31:0]       dt;
    logic [2:0]        kty;
    logic              k_fd;
    logic [7:0]        kcnt_new;
    logic              k_fire_m;
    logic              cross_hit;

    assign learning = learning_reg;

    always_comb
    begin
        cur_match = 1'b0;
        if (valid_reg[ptr_reg] && enabled_reg[ptr_reg])
        begin
            if (type_reg[ptr_reg] == T_REMOTE)
            begin
                cur_match = (id_reg[ptr_reg][31:8] == sid_reg[31:8]);
            end
            else
            begin
                cur_match = (id_reg[ptr_reg] == sid_reg);
            end
        end
        cur_dup  = valid_reg[ptr_reg] && (id_reg[ptr_reg] == sid_reg);
        cur_free = !valid_reg[ptr_reg];
    end

    always_comb
    begin
        sts.last = (ptr_reg == SLOT_W'(TABLE_SLOTS - 1));
        case (cmd.scan_kind)
            SCAN_DUP:   sts.hit = cur_dup;
            SCAN_MATCH: sts.hit = cur_match;
            SCAN_FREE:  sts.hit = cur_free;
            default:    sts.hit = 1'b0;
        endcase
    end

    assign kty = type_reg[hit_slot_reg];
    assign k_fd = (kty == T_DOOR) || (kty == T_CURTAIN) || (kty == T_PIR);
    // Matched slot found this cycle on the final match step and needs the rules.
    assign judge_multi_needed =
        cur_match && (type_reg[ptr_reg] == T_DOOR || type_reg[ptr_reg] == T_CURTAIN
                      || type_reg[ptr_reg] == T_PIR);

    assign multi = (doors_reg != '0) ? (pirs_reg != '0) : (pirs_reg >= CNT_W'(2));
    assign dt    = now_reg - time_reg[hit_slot_reg];

    always_comb
    begin
        kcnt_new = trig_reg[hit_slot_reg];
        k_fire_m = 1'b0;
        if (dt >= {24'd0, window_reg})
        begin
            kcnt_new = 8'd1;
        end
        else
        begin
            if (dt > {24'd0, gap_reg} && trig_reg[hit_slot_reg] != 8'hFF)
            begin
                kcnt_new = trig_reg[hit_slot_reg] + 8'd1;
            end
            k_fire_m = (kcnt_new >= count_reg);
        end
    end

    assign cross_needed = multi && (kty == T_DOOR || kty == T_PIR);
    assign cross_hit = enabled_reg[ptr_reg] && (trig_reg[ptr_reg] != 8'd0)
                       && (id_reg[ptr_reg] != id_reg[hit_slot_reg])
                       && (type_reg[ptr_reg] == T_DOOR || type_reg[ptr_reg] == T_PIR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= 8'd10;
            gap_reg        <= 8'd2;
            count_reg      <= 8'd2;
            timeout_reg    <= 8'd100;
            valid_reg      <= '0;
            enabled_reg    <= '0;
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                type_reg[i] <= '0;
                id_reg[i]   <= '0;
                time_reg[i] <= '0;
                trig_reg[i] <= '0;
            end
            learning_reg   <= 1'b0;
            learn_slot_reg <= '0;
            countdown_reg  <= 8'd100;
            armed_reg      <= 1'b1;
            ptr_reg        <= '0;
            found_reg      <= 1'b0;
            hit_slot_reg   <= '0;
            doors_reg      <= '0;
            pirs_reg       <= '0;
            fire_reg       <= 1'b0;
            done           <= 1'b0;
            event_res      <= EV_NONE;
            slot           <= '0;
            alarm_type     <= '0;
            req_reg        <= '0;
            sid_reg        <= '0;
            now_reg        <= '0;
            nty_reg        <= '0;
            idx_reg        <= '0;
            en_reg         <= 1'b0;
        end
        else
        begin
            done       <= 1'b0;
            event_res  <= EV_NONE;
            slot       <= '0;
            alarm_type <= '0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WINDOW:  window_reg  <= cfg_data;
                    CFG_GAP:     gap_reg     <= cfg_data;
                    CFG_COUNT:   count_reg   <= cfg_data;
                    CFG_TIMEOUT: timeout_reg <= cfg_data;
                    default:     window_reg  <= window_reg;
                endcase
            end
            if (cmd.load)
            begin
                req_reg   <= req_type;
                sid_reg   <= sensor_id;
                now_reg   <= now_seconds;
                nty_reg   <= new_type;
                idx_reg   <= entry_index;
                en_reg    <= entry_enable;
                found_reg <= 1'b0;
                doors_reg <= '0;
                pirs_reg  <= '0;
                fire_reg  <= 1'b0;
            end
            if (cmd.clr_scan)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.adv)
            begin
                ptr_reg <= ptr_reg + SLOT_W'(1);
            end
            if (cmd.scan_step)
            begin
                case (cmd.scan_kind)
                    SCAN_DUP, SCAN_MATCH, SCAN_FREE:
                    begin
                        if (sts.hit)
                        begin
                            found_reg    <= 1'b1;
                            hit_slot_reg <= ptr_reg;
                        end
                    end
                    SCAN_MULTI:
                    begin
                        if (valid_reg[ptr_reg] && enabled_reg[ptr_reg])
                        begin
                            if (type_reg[ptr_reg] == T_DOOR)
                            begin
                                doors_reg <= doors_reg + CNT_W'(1);
                            end
                            if (type_reg[ptr_reg] == T_PIR)
                            begin
                                pirs_reg <= pirs_reg + CNT_W'(1);
                            end
                        end
                    end
                    SCAN_CROSS:
                    begin
                        // The matched slot's own count is updated on the first step.
                        if (ptr_reg == SLOT_W'(0))
                        begin
                            trig_reg[hit_slot_reg] <= kcnt_new;
                            time_reg[hit_slot_reg] <= now_reg;
                            fire_reg <= k_fire_m || cross_hit;
                        end
                        else if (cross_hit)
                        begin
                            fire_reg <= 1'b1;
                        end
                        if (cross_hit)
                        begin
                            trig_reg[ptr_reg] <= 8'd0;
                        end
                    end
                    default:
                    begin
                        found_reg <= found_reg;
                    end
                endcase
            end
            if (cmd.finish)
            begin
                done <= 1'b1;
                case (req_reg)
                    REQ_ID:
                    begin
                        if (learning_reg)
                        begin
                            if (found_reg)
                            begin
                                event_res <= EV_DUP;
                                slot      <= 4'(hit_slot_reg);
                            end
                            else
                            begin
                                id_reg[learn_slot_reg]    <= sid_reg;
                                valid_reg[learn_slot_reg] <= 1'b1;
                                learning_reg              <= 1'b0;
                                event_res                 <= EV_LEARNED;
                                slot                      <= 4'(learn_slot_reg);
                            end
                        end
                        else if (found_reg && kty == T_REMOTE)
                        begin
                            if ((sid_reg[7:0] & ARM_BITS) == ARM_BITS)
                            begin
                                armed_reg <= 1'b1;
                                event_res <= EV_ARMED;
                                slot      <= 4'(hit_slot_reg);
                            end
                            else if ((sid_reg[7:0] & PANIC_BITS) == PANIC_BITS)
                            begin
                                event_res <= EV_NONE;
                            end
                            else if ((sid_reg[7:0] & DISARM_BITS) == DISARM_BITS)
                            begin
                                armed_reg <= 1'b0;
                                event_res <= EV_DISARM;
                                slot      <= 4'(hit_slot_reg);
                            end
                        end
                        else if (found_reg)
                        begin
                            logic fire;
                            logic upd_cnt;
                            fire    = 1'b0;
                            upd_cnt = 1'b0;
                            if (kty == T_WRIST || kty == T_SMOKE || kty == T_GAS)
                            begin
                                fire = 1'b1;
                            end
                            else if (k_fd)
                            begin
                                if (multi)
                                begin
                                    if (cross_needed)
                                    begin
                                        fire = fire_reg;
                                    end
                                    else
                                    begin
                                        fire    = k_fire_m;
                                        upd_cnt = 1'b1;
                                        time_reg[hit_slot_reg] <= now_reg;
                                    end
                                end
                                else if (dt >= {24'd0, gap_reg})
                                begin
                                    time_reg[hit_slot_reg] <= now_reg;
                                    fire = 1'b1;
                                end
                            end
                            if ((enabled_reg[hit_slot_reg] && fire && armed_reg)
                                || kty == T_WRIST)
                            begin
                                trig_reg[hit_slot_reg] <= 8'd0;
                                event_res  <= EV_ALARM;
                                slot       <= 4'(hit_slot_reg);
                                alarm_type <= kty;
                            end
                            else if (upd_cnt)
                            begin
                                trig_reg[hit_slot_reg] <= kcnt_new;
                            end
                        end
                    end
                    REQ_POLL:
                    begin
                        if (learning_reg)
                        begin
                            if (countdown_reg == 8'd0)
                            begin
                                learning_reg <= 1'b0;
                                event_res    <= EV_TIMEOUT;
                            end
                            else
                            begin
                                countdown_reg <= countdown_reg - 8'd1;
                            end
                        end
                    end
                    REQ_LEARN:
                    begin
                        if (!found_reg)
                        begin
                            event_res <= EV_FULL;
                        end
                        else
                        begin
                            type_reg[hit_slot_reg] <= nty_reg;
                            learn_slot_reg         <= hit_slot_reg;
                            countdown_reg          <= timeout_reg;
                            learning_reg           <= 1'b1;
                        end
                    end
                    REQ_ENABLE:
                    begin
                        if (idx_reg >= 8'(TABLE_SLOTS) || !valid_reg[idx_reg[SLOT_W-1:0]])
                        begin
                            event_res <= EV_REJECT;
                        end
                        else
                        begin
                            enabled_reg[idx_reg[SLOT_W-1:0]] <= en_reg;
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (idx_reg >= 8'(TABLE_SLOTS))
                        begin
                            event_res <= EV_REJECT;
                        end
                        else
                        begin
                            valid_reg[idx_reg[SLOT_W-1:0]]   <= 1'b0;
                            enabled_reg[idx_reg[SLOT_W-1:0]] <= 1'b0;
                            type_reg[idx_reg[SLOT_W-1:0]]    <= '0;
                            id_reg[idx_reg[SLOT_W-1:0]]      <= '0;
                            time_reg[idx_reg[SLOT_W-1:0]]    <= '0;
                            trig_reg[idx_reg[SLOT_W-1:0]]    <= '0;
                        end
                    end
                    default:
                    begin
                        event_res <= EV_NONE;
                    end
                endcase
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_event_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (event_res != EV_NONE) |-> done) else $error("event without strobe");
    a_alarm_type: assert property (@(posedge clk) disable iff (!rst_n)
        (done && event_res != EV_ALARM) |-> (alarm_type == 3'd0))
        else $error("alarm type outside alarm");
    a_learn_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (done && event_res == EV_LEARNED) |-> !learning_reg)
        else $error("learning still active after bind");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sensor learn and alarm table core. A table of
// directed items checks resets, extremes and error codes, then three random
// phases under different register settings run learned IDs, remotes, polls,
// learn, enable and delete requests. Each result is compared with the fixed
// result of its directed item or with a behavioural model held in the bench.
// ----------------------------------------------------------------------------
module tb;
    import rfsla_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 60;

    typedef struct {
        logic [2:0]  req;
        logic [31:0] id;
        logic [31:0] secs;
        logic [2:0]  nty;
        logic [7:0]  idx;
        logic        en;
        bit          fixed;
        logic [3:0]  ev;
        logic [3:0]  sl;
        logic [2:0]  aty;
    } item_t;

    typedef struct {
        logic [3:0] ev;
        logic [3:0] sl;
        logic [2:0] aty;
    } event_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        start;
    logic        busy;
    logic [2:0]  req_type;
    logic [31:0] sensor_id;
    logic [31:0] now_seconds;
    logic [2:0]  new_type;
    logic [7:0]  entry_index;
    logic        entry_enable;
    logic        done;
    logic [3:0]  event_res;
    logic [3:0]  slot;
    logic [2:0]  alarm_type;

    rf_sensor_learn_and_alarm_table_core u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .sensor_id    (sensor_id),
        .now_seconds  (now_seconds),
        .new_type     (new_type),
        .entry_index  (entry_index),
        .entry_enable (entry_enable),
        .done         (done),
        .event_res    (event_res),
        .slot         (slot),
        .alarm_type   (alarm_type)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Model of the table and its registers.
    logic [7:0]  reg_window;
    logic [7:0]  reg_gap;
    logic [7:0]  reg_count;
    logic [7:0]  reg_timeout;
    logic        tbl_valid [TABLE_SLOTS];
    logic        tbl_enabled [TABLE_SLOTS];
    logic [2:0]  tbl_type [TABLE_SLOTS];
    logic [31:0] tbl_id [TABLE_SLOTS];
    logic [31:0] tbl_last [TABLE_SLOTS];
    logic [7:0]  tbl_count [TABLE_SLOTS];
    logic        learning;
    int          learn_slot_idx;
    logic [7:0]  learn_left;
    logic        sys_armed;

    event_t      expected_q[$];
    item_t       cur_item;
    int          idle_pct;
    int          errors;
    int          items_sent;
    int          alarms_seen;
    int          quiet_cycles;
    logic [31:0] clock_secs;

    function automatic event_t mk_event(logic [3:0] ev, int sl, logic [2:0] aty);
        event_t e;
        e.ev = ev;
        e.sl = sl[3:0];
        e.aty = aty;
        return e;
    endfunction

    function automatic bit multi_sensor_mode();
        int doors;
        int pirs;
        doors = 0;
        pirs = 0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (tbl_valid[i] && tbl_enabled[i])
            begin
                if (tbl_type[i] == T_DOOR) doors++;
                if (tbl_type[i] == T_PIR) pirs++;
            end
        end
        if (doors > 0) return pirs > 0;
        return pirs >= 2;
    endfunction

    function automatic event_t judge_trigger(int k, logic [31:0] t_now);
        logic [2:0]  ty;
        logic [31:0] dt;
        bit          fire;
        ty = tbl_type[k];
        dt = t_now - tbl_last[k];
        fire = 1'b0;
        if (ty == T_WRIST || ty == T_SMOKE || ty == T_GAS)
        begin
            fire = 1'b1;
        end
        else if (ty == T_DOOR || ty == T_CURTAIN || ty == T_PIR)
        begin
            if (multi_sensor_mode())
            begin
                if (dt >= {24'd0, reg_window})
                begin
                    tbl_last[k] = t_now;
                    tbl_count[k] = 8'd1;
                end
                else
                begin
                    if (dt > {24'd0, reg_gap} && tbl_count[k] < 8'd255)
                        tbl_count[k] = tbl_count[k] + 8'd1;
                    tbl_last[k] = t_now;
                    if (tbl_count[k] >= reg_count) fire = 1'b1;
                end
                if (ty == T_DOOR || ty == T_PIR)
                begin
                    for (int i = 0; i < TABLE_SLOTS; i++)
                    begin
                        if (tbl_enabled[i] && tbl_count[i] >= 8'd1 && tbl_id[i] != tbl_id[k]
                            && (tbl_type[i] == T_DOOR || tbl_type[i] == T_PIR))
                        begin
                            fire = 1'b1;
                            tbl_count[i] = 8'd0;
                        end
                    end
                end
            end
            else if (dt >= {24'd0, reg_gap})
            begin
                tbl_last[k] = t_now;
                fire = 1'b1;
            end
        end
        if ((tbl_enabled[k] && fire && sys_armed) || ty == T_WRIST)
        begin
            tbl_count[k] = 8'd0;
            return mk_event(EV_ALARM, k, ty);
        end
        return mk_event(EV_NONE, 0, 3'd0);
    endfunction

    function automatic event_t received_id(logic [31:0] id, logic [31:0] t_now);
        int hit;
        hit = -1;
        if (learning)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
                if (hit < 0 && tbl_valid[i] && tbl_id[i] == id) hit = i;
            if (hit >= 0) return mk_event(EV_DUP, hit, 3'd0);
            tbl_id[learn_slot_idx] = id;
            tbl_valid[learn_slot_idx] = 1'b1;
            learning = 1'b0;
            return mk_event(EV_LEARNED, learn_slot_idx, 3'd0);
        end
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (hit < 0 && tbl_valid[i] && tbl_enabled[i])
            begin
                if (tbl_type[i] == T_REMOTE)
                begin
                    if (tbl_id[i][31:8] == id[31:8]) hit = i;
                end
                else if (tbl_id[i] == id)
                begin
                    hit = i;
                end
            end
        end
        if (hit < 0) return mk_event(EV_NONE, 0, 3'd0);
        if (tbl_type[hit] == T_REMOTE)
        begin
            if ((id[7:0] & ARM_BITS) == ARM_BITS)
            begin
                sys_armed = 1'b1;
                return mk_event(EV_ARMED, hit, 3'd0);
            end
            if ((id[7:0] & PANIC_BITS) == PANIC_BITS) return mk_event(EV_NONE, 0, 3'd0);
            if ((id[7:0] & DISARM_BITS) == DISARM_BITS)
            begin
                sys_armed = 1'b0;
                return mk_event(EV_DISARM, hit, 3'd0);
            end
            return mk_event(EV_NONE, 0, 3'd0);
        end
        return judge_trigger(hit, t_now);
    endfunction

    function automatic event_t sensor_table_step(item_t it);
        event_t r;
        int     fr;
        r = mk_event(EV_NONE, 0, 3'd0);
        fr = -1;
        case (it.req)
            REQ_ID:
                r = received_id(it.id, it.secs);
            REQ_POLL:
                if (learning)
                begin
                    if (learn_left == 8'd0)
                    begin
                        learning = 1'b0;
                        r = mk_event(EV_TIMEOUT, 0, 3'd0);
                    end
                    else
                    begin
                        learn_left = learn_left - 8'd1;
                    end
                end
            REQ_LEARN:
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                    if (fr < 0 && !tbl_valid[i]) fr = i;
                if (fr < 0)
                begin
                    r = mk_event(EV_FULL, 0, 3'd0);
                end
                else
                begin
                    tbl_type[fr] = it.nty;
                    learn_slot_idx = fr;
                    learn_left = reg_timeout;
                    learning = 1'b1;
                end
            end
            REQ_ENABLE:
                if (it.idx >= TABLE_SLOTS || !tbl_valid[it.idx])
                    r = mk_event(EV_REJECT, 0, 3'd0);
                else
                    tbl_enabled[it.idx] = it.en;
            REQ_DELETE:
                if (it.idx >= TABLE_SLOTS)
                begin
                    r = mk_event(EV_REJECT, 0, 3'd0);
                end
                else
                begin
                    tbl_valid[it.idx] = 1'b0;
                    tbl_enabled[it.idx] = 1'b0;
                    tbl_type[it.idx] = 3'd0;
                    tbl_id[it.idx] = 32'd0;
                    tbl_last[it.idx] = 32'd0;
                    tbl_count[it.idx] = 8'd0;
                end
            default:
                r = mk_event(EV_NONE, 0, 3'd0);
        endcase
        return r;
    endfunction

    // Results are compared before new expectations are queued, so a result
    // and an acceptance on the same edge are kept in order.
    always @(posedge clk)
    begin
        event_t exp_ev;
        event_t pred;
        bit     moved;
        moved = 1'b0;
        if (rst_n && done === 1'b1)
        begin
            moved = 1'b1;
            if (event_res == EV_ALARM) alarms_seen++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result ev=%0d slot=%0d type=%0d",
                         $time, event_res, slot, alarm_type);
                errors++;
            end
            else
            begin
                exp_ev = expected_q.pop_front();
                if (event_res !== exp_ev.ev)
                begin
                    $display("%0t: event_res expected %0d actual %0d", $time, exp_ev.ev, event_res);
                    errors++;
                end
                if (slot !== exp_ev.sl)
                begin
                    $display("%0t: slot expected %0d actual %0d", $time, exp_ev.sl, slot);
                    errors++;
                end
                if (alarm_type !== exp_ev.aty)
                begin
                    $display("%0t: alarm_type expected %0d actual %0d",
                             $time, exp_ev.aty, alarm_type);
                    errors++;
                end
            end
        end
        if (rst_n && start === 1'b1 && busy === 1'b0)
        begin
            moved = 1'b1;
            pred = sensor_table_step(cur_item);
            if (cur_item.fixed)
                expected_q.push_back(mk_event(cur_item.ev, cur_item.sl, cur_item.aty));
            else
                expected_q.push_back(pred);
        end
        if (!rst_n || moved || (start !== 1'b1 && expected_q.size() == 0))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(item_t it);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        cur_item <= it;
        req_type <= it.req;
        sensor_id <= it.id;
        now_seconds <= it.secs;
        new_type <= it.nty;
        entry_index <= it.idx;
        entry_enable <= it.en;
        start <= 1'b1;
        do @(posedge clk); while (busy !== 1'b0);
        items_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WINDOW:  reg_window = val;
            CFG_GAP:     reg_gap = val;
            CFG_COUNT:   reg_count = val;
            CFG_TIMEOUT: reg_timeout = val;
            default:     ;
        endcase
    endtask

    task automatic set_all_regs(logic [7:0] w, logic [7:0] g, logic [7:0] c, logic [7:0] t);
        write_reg(CFG_WINDOW, w);
        write_reg(CFG_GAP, g);
        write_reg(CFG_COUNT, c);
        write_reg(CFG_TIMEOUT, t);
        @(posedge clk);
    endtask

    function automatic item_t mk_item(logic [2:0] req, logic [31:0] id, logic [31:0] secs,
                                      logic [2:0] nty, logic [7:0] idx, logic en);
        item_t it;
        it.req = req;
        it.id = id;
        it.secs = secs;
        it.nty = nty;
        it.idx = idx;
        it.en = en;
        it.fixed = 1'b0;
        it.ev = EV_NONE;
        it.sl = 4'd0;
        it.aty = 3'd0;
        return it;
    endfunction

    function automatic item_t with_result(item_t it, logic [3:0] ev, logic [3:0] sl);
        it.fixed = 1'b1;
        it.ev = ev;
        it.sl = sl;
        it.aty = 3'd0;
        return it;
    endfunction

    function automatic item_t random_item();
        item_t       it;
        int          pick;
        int          k;
        logic [31:0] base;
        pick = $urandom_range(99);
        clock_secs = clock_secs + $urandom_range(0, 12);
        if ($urandom_range(49) == 0) clock_secs = $urandom;
        it = mk_item(REQ_ID, $urandom, clock_secs, 3'($urandom_range(1, 7)),
                     8'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        if ($urandom_range(19) == 0) it.nty = 3'd0;
        if ($urandom_range(9) == 0) it.idx = 8'($urandom_range(0, 255));
        if (pick < 45)
        begin
            k = $urandom_range(0, TABLE_SLOTS - 1);
            base = tbl_valid[k] ? tbl_id[k] : $urandom;
            if (tbl_type[k] == T_REMOTE) it.id = {base[31:8], 8'($urandom)};
            else it.id = base;
        end
        else if (pick < 52)
        begin
            it.req = REQ_ID;
        end
        else if (pick < 67)
        begin
            it.req = REQ_POLL;
        end
        else if (pick < 79)
        begin
            it.req = REQ_LEARN;
        end
        else if (pick < 91)
        begin
            it.req = REQ_ENABLE;
            if ($urandom_range(3) != 0) it.en = 1'b1;
        end
        else if (pick < 97)
        begin
            it.req = REQ_DELETE;
        end
        else
        begin
            it.req = 3'($urandom_range(5, 7));
        end
        return it;
    endfunction

    task automatic random_phase(int count, int pct);
        idle_pct = pct;
        for (int n = 0; n < count; n++) send_item(random_item());
    endtask

    initial
    begin
        item_t dir_tab[$];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 2'd0;
        cfg_data = 8'd0;
        start = 1'b0;
        req_type = 3'd0;
        sensor_id = 32'd0;
        now_seconds = 32'd0;
        new_type = 3'd0;
        entry_index = 8'd0;
        entry_enable = 1'b0;
        errors = 0;
        items_sent = 0;
        alarms_seen = 0;
        quiet_cycles = 0;
        clock_secs = 32'd0;
        idle_pct = 36;
        reg_window = 8'd10;
        reg_gap = 8'd2;
        reg_count = 8'd2;
        reg_timeout = 8'd100;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_enabled[i] = 1'b0;
            tbl_type[i] = 3'd0;
            tbl_id[i] = 32'd0;
            tbl_last[i] = 32'd0;
            tbl_count[i] = 8'd0;
        end
        learning = 1'b0;
        learn_slot_idx = 0;
        learn_left = 8'd100;
        sys_armed = 1'b1;
        cur_item = mk_item(REQ_POLL, 32'd0, 32'd0, 3'd0, 8'd0, 1'b0);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_tab.push_back(with_result(mk_item(REQ_POLL, 0, 0, 0, 0, 0), EV_NONE, 0));
        dir_tab.push_back(with_result(mk_item(REQ_ID, 32'h12345678, 0, 0, 0, 0), EV_NONE, 0));
        dir_tab.push_back(with_result(mk_item(REQ_ENABLE, 0, 0, 0, 0, 1), EV_REJECT, 0));
        dir_tab.push_back(with_result(mk_item(REQ_DELETE, 0, 0, 0, 8'd255, 0), EV_REJECT, 0));
        dir_tab.push_back(with_result(mk_item(REQ_ENABLE, 0, 0, 0, 8'd16, 1), EV_REJECT, 0));
        dir_tab.push_back(with_result(mk_item(REQ_LEARN, 0, 0, T_DOOR, 0, 0), EV_NONE, 0));
        dir_tab.push_back(with_result(mk_item(REQ_ID, 32'hFFFFFFFF, 0, 0, 0, 0),
                                      EV_LEARNED, 0));
        dir_tab.push_back(with_result(mk_item(REQ_LEARN, 0, 0, T_PIR, 0, 0), EV_NONE, 0));
        dir_tab.push_back(with_result(mk_item(REQ_ID, 32'hFFFFFFFF, 0, 0, 0, 0), EV_DUP, 0));
        dir_tab.push_back(with_result(mk_item(REQ_ID, 32'h00000000, 0, 0, 0, 0),
                                      EV_LEARNED, 1));
        dir_tab.push_back(with_result(mk_item(REQ_ENABLE, 0, 0, 0, 0, 1), EV_NONE, 0));
        dir_tab.push_back(with_result(mk_item(REQ_ENABLE, 0, 0, 0, 1, 1), EV_NONE, 0));
        dir_tab.push_back(mk_item(REQ_LEARN, 0, 0, T_WRIST, 0, 0));
        dir_tab.push_back(mk_item(REQ_ID, 32'hAAAA5555, 0, 0, 0, 0));
        dir_tab.push_back(mk_item(REQ_ENABLE, 0, 0, 0, 2, 1));
        dir_tab.push_back(mk_item(REQ_LEARN, 0, 0, T_REMOTE, 0, 0));
        dir_tab.push_back(mk_item(REQ_ID, 32'h00C0FF00, 0, 0, 0, 0));
        dir_tab.push_back(mk_item(REQ_ENABLE, 0, 0, 0, 3, 1));
        dir_tab.push_back(mk_item(REQ_ID, 32'h00C0FF03, 5, 0, 0, 0));
        dir_tab.push_back(mk_item(REQ_ID, 32'hAAAA5555, 6, 0, 0, 0));
        dir_tab.push_back(mk_item(REQ_ID, 32'h00C0FF0C, 7, 0, 0, 0));
        dir_tab.push_back(mk_item(REQ_ID, 32'h00C0FF30, 8, 0, 0, 0));
        dir_tab.push_back(mk_item(REQ_ID, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0));
        dir_tab.push_back(mk_item(REQ_ID, 32'h00000000, 32'h00000003, 0, 0, 0));
        dir_tab.push_back(mk_item(REQ_LEARN, 0, 0, 3'd0, 0, 0));
        dir_tab.push_back(mk_item(REQ_DELETE, 0, 0, 0, 4, 0));
        dir_tab.push_back(with_result(mk_item(3'd7, 0, 0, 0, 0, 0), EV_NONE, 0));
        foreach (dir_tab[i]) send_item(dir_tab[i]);

        drain_results();
        set_all_regs(8'd1, 8'd0, 8'd1, 8'd0);
        random_phase(200, 36);
        drain_results();
        set_all_regs(8'd255, 8'd255, 8'd255, 8'd255);
        random_phase(200, 52);
        drain_results();
        set_all_regs(8'($urandom_range(1, 20)), 8'($urandom_range(0, 4)),
                     8'($urandom_range(1, 4)), 8'($urandom_range(0, 10)));
        random_phase(200, 0);

        drain_results();
        $display("Ran %0d items over four register settings, %0d alarms raised.",
                 items_sent, alarms_seen);
        if (errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("%0d mismatches", errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule
